// ===== rtl/core/rpc_pkg.sv =====
// Shared types, codes and register indexes of the RGB565 pixel combine core.
`default_nettype none

package rpc_pkg;

  // Widths of the datapath.
  localparam int unsigned PixW    = 16;
  localparam int unsigned NumW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_FORMAT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLEND  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TINT_R = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TINT_G = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TINT_B = 3'd5;

  // Reset value of the key register: no colour key.
  localparam logic [PixW-1:0] NO_KEY = 16'hFFFF;

  // Command codes carried by an input word.
  typedef enum logic [1:0] {
    CMD_KEYED = 2'd0,
    CMD_TINT  = 2'd1,
    CMD_EDGE  = 2'd2
  } cmd_e;

  // How the second stage forms the pixel.
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_COPY,
    RES_BLEND,
    RES_TINT,
    RES_MEAN
  } kind_e;

  // Configuration registers.
  typedef struct packed {
    logic            format_rgb565;
    logic [PixW-1:0] key_colour;
    logic [6:0]      blend_percent;
    logic [7:0]      tint_red;
    logic [7:0]      tint_green;
    logic [7:0]      tint_blue;
  } cfg_t;

  // One input word as held in the input register.
  typedef struct packed {
    logic [1:0]      command;
    logic [PixW-1:0] src_pixel;
    logic [PixW-1:0] dst_pixel;
    logic [PixW-1:0] left_pixel;
    logic [PixW-1:0] right_pixel;
    logic [PixW-1:0] up_pixel;
    logic [PixW-1:0] down_pixel;
    logic            first_col;
    logic            last_col;
    logic            first_row;
    logic            last_row;
  } item_t;

  // Partial result between the two compute stages.
  typedef struct packed {
    kind_e           kind;
    logic            write_enable;
    logic [PixW-1:0] pixel;
    logic [NumW-1:0] num_r;
    logic [NumW-1:0] num_g;
    logic [NumW-1:0] num_b;
  } mid_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpc_prep.sv =====
// First compute stage: classifies the word and forms the weighted channel sums.
`default_nettype none

module rpc_prep (
  input  rpc_pkg::item_t item_i,
  input  rpc_pkg::cfg_t  cfg_i,
  output rpc_pkg::mid_t  mid_o
);
  import rpc_pkg::*;

  // Eight-bit channel expansion of an RGB565 pixel.
  function automatic logic [7:0] red8(input logic [PixW-1:0] p);
    red8 = {p[15:11], 3'b000};
  endfunction

  function automatic logic [7:0] green8(input logic [PixW-1:0] p);
    green8 = {p[10:5], 2'b00};
  endfunction

  function automatic logic [7:0] blue8(input logic [PixW-1:0] p);
    blue8 = {p[4:0], 3'b000};
  endfunction

  logic            not_key;
  logic [6:0]      alpha;
  logic [6:0]      inv_alpha;
  logic [7:0]      cov;
  logic [7:0]      inv_cov;
  logic [NumW-1:0] blend_r, blend_g, blend_b;
  logic [NumW-1:0] tint_r, tint_g, tint_b;
  logic [PixW-1:0] nb [4];
  logic [3:0]      use_nb;
  logic            lr_ok;
  logic            ud_ok;
  logic [2:0]      n_used;
  logic [2:0]      w_dst;
  logic [10:0]     sum_r, sum_g;
  logic [7:0]      sum_b;

  assign not_key = (cfg_i.key_colour == NO_KEY) || (item_i.src_pixel != cfg_i.key_colour);

  // Keyed blend: destination weight saturates at one hundred percent.
  assign alpha     = (cfg_i.blend_percent > 7'd100) ? 7'd100 : cfg_i.blend_percent;
  assign inv_alpha = 7'd100 - alpha;
  assign blend_r = NumW'(inv_alpha) * NumW'(red8(item_i.src_pixel))
                 + NumW'(alpha) * NumW'(red8(item_i.dst_pixel));
  assign blend_g = NumW'(inv_alpha) * NumW'(green8(item_i.src_pixel))
                 + NumW'(alpha) * NumW'(green8(item_i.dst_pixel));
  assign blend_b = NumW'(inv_alpha) * NumW'(blue8(item_i.src_pixel))
                 + NumW'(alpha) * NumW'(blue8(item_i.dst_pixel));

  // Glyph tint: the source blue channel is the coverage.
  assign cov     = blue8(item_i.src_pixel);
  assign inv_cov = 8'hFF - cov;
  assign tint_r = NumW'(inv_cov) * NumW'(red8(item_i.dst_pixel))
                + NumW'(cov) * NumW'(cfg_i.tint_red);
  assign tint_g = NumW'(inv_cov) * NumW'(green8(item_i.dst_pixel))
                + NumW'(cov) * NumW'(cfg_i.tint_green);
  assign tint_b = NumW'(inv_cov) * NumW'(blue8(item_i.dst_pixel))
                + NumW'(cov) * NumW'(cfg_i.tint_blue);

  // Edge mean: column neighbours count only away from a column edge, row
  // neighbours only away from a row edge; neighbours equal to the key drop out
  // and the destination takes their weight.
  assign nb[0] = item_i.left_pixel;
  assign nb[1] = item_i.right_pixel;
  assign nb[2] = item_i.up_pixel;
  assign nb[3] = item_i.down_pixel;
  assign lr_ok = !item_i.first_col && !item_i.last_col;
  assign ud_ok = !item_i.first_row && !item_i.last_row;
  assign use_nb[0] = lr_ok && (nb[0] != cfg_i.key_colour);
  assign use_nb[1] = lr_ok && (nb[1] != cfg_i.key_colour);
  assign use_nb[2] = ud_ok && (nb[2] != cfg_i.key_colour);
  assign use_nb[3] = ud_ok && (nb[3] != cfg_i.key_colour);
  assign n_used = 3'(use_nb[0]) + 3'(use_nb[1]) + 3'(use_nb[2]) + 3'(use_nb[3]);
  assign w_dst  = 3'd5 - n_used;

  always_comb begin
    sum_r = 11'(red8(item_i.dst_pixel)) * 11'(w_dst);
    sum_g = 11'(green8(item_i.dst_pixel)) * 11'(w_dst);
    sum_b = 8'(item_i.dst_pixel[4:0]) * 8'(w_dst);
    for (int i = 0; i < 4; i++) begin
      if (use_nb[i]) begin
        sum_r = sum_r + 11'(red8(nb[i]));
        sum_g = sum_g + 11'(green8(nb[i]));
        sum_b = sum_b + 8'(nb[i][4:0]);
      end
    end
  end

  // Decide how the pixel is formed and whether it is written.
  always_comb begin
    mid_o.kind         = RES_ZERO;
    mid_o.write_enable = 1'b0;
    mid_o.pixel        = item_i.src_pixel;
    mid_o.num_r        = blend_r;
    mid_o.num_g        = blend_g;
    mid_o.num_b        = blend_b;
    unique case (cmd_e'(item_i.command))
      CMD_KEYED: begin
        if (not_key) begin
          mid_o.write_enable = 1'b1;
          if (alpha == 7'd0) begin
            mid_o.kind = RES_COPY;
          end else if (cfg_i.format_rgb565) begin
            mid_o.kind = RES_BLEND;
          end
        end
      end
      CMD_TINT: begin
        mid_o.write_enable = 1'b1;
        mid_o.num_r        = tint_r;
        mid_o.num_g        = tint_g;
        mid_o.num_b        = tint_b;
        if (cfg_i.format_rgb565) begin
          mid_o.kind = RES_TINT;
        end
      end
      CMD_EDGE: begin
        mid_o.num_r = NumW'(sum_r);
        mid_o.num_g = NumW'(sum_g);
        mid_o.num_b = NumW'({sum_b, 3'b000});
        if (not_key) begin
          mid_o.write_enable = 1'b1;
          mid_o.kind         = RES_COPY;
        end else if (lr_ok || ud_ok) begin
          mid_o.write_enable = 1'b1;
          if (cfg_i.format_rgb565) begin
            mid_o.kind = RES_MEAN;
          end
        end
      end
      default: begin
        mid_o.kind         = RES_ZERO;
        mid_o.write_enable = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpc_finish.sv =====
// Second compute stage: constant divisions by reciprocal and RGB565 packing.
`default_nettype none

module rpc_finish (
  input  rpc_pkg::mid_t            mid_i,
  output logic [rpc_pkg::PixW-1:0] pixel_o
);
  import rpc_pkg::*;

  // Reciprocals: x/25 as (x*5243)>>17 and x/5 as (x*1639)>>13, exact over
  // the ranges reached here.
  localparam logic [12:0] Recip25 = 13'd5243;
  localparam logic [10:0] Recip5  = 11'd1639;

  // Percent blend: divide by four, then by twenty-five.
  function automatic logic [7:0] div100(input logic [NumW-1:0] x);
    logic [27:0] prod;
    prod   = 28'(x[NumW-1:2]) * 28'(Recip25);
    div100 = prod[24:17];
  endfunction

  // Tint: x/255 for x up to 255*255.
  function automatic logic [7:0] div255(input logic [NumW-1:0] x);
    logic [16:0] s;
    s      = 17'(x) + 17'(x[NumW-1:8]) + 17'd1;
    div255 = s[15:8];
  endfunction

  // Edge mean: x/5 for x below 2048.
  function automatic logic [7:0] div5(input logic [NumW-1:0] x);
    logic [21:0] prod;
    prod = 22'(x[10:0]) * 22'(Recip5);
    div5 = prod[20:13];
  endfunction

  function automatic logic [7:0] chan(input kind_e k, input logic [NumW-1:0] x);
    unique case (k)
      RES_BLEND: chan = div100(x);
      RES_TINT:  chan = div255(x);
      RES_MEAN:  chan = div5(x);
      default:   chan = 8'd0;
    endcase
  endfunction

  logic [7:0] r8, g8, b8;

  assign r8 = chan(mid_i.kind, mid_i.num_r);
  assign g8 = chan(mid_i.kind, mid_i.num_g);
  assign b8 = chan(mid_i.kind, mid_i.num_b);

  // Pack; the lowest green bit of a computed pixel is always clear.
  always_comb begin
    unique case (mid_i.kind)
      RES_COPY:                     pixel_o = mid_i.pixel;
      RES_BLEND, RES_TINT, RES_MEAN: pixel_o = {r8[7:3], g8[7:3], 1'b0, b8[7:3]};
      default:                      pixel_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rgb565_pixel_combine_core.sv =====
// Top level of the RGB565 pixel combine core: registers, pipeline control, config.
// An accepted word moves through the input, sums and result registers in turn.
// Throughput: one word per cycle; the three-register pipeline (input, sums, result)
// advances whenever the result register is empty or its word is taken.
// Stalls back-pressure through the ready chain without losing or repeating words.
// Reset empties the pipeline and loads the registers with format on, no key,
// zero blend and black tint.
`default_nettype none

module rgb565_pixel_combine_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [rpc_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  command_i,
  input  wire logic [rpc_pkg::PixW-1:0]    src_pixel_i,
  input  wire logic [rpc_pkg::PixW-1:0]    dst_pixel_i,
  input  wire logic [rpc_pkg::PixW-1:0]    left_pixel_i,
  input  wire logic [rpc_pkg::PixW-1:0]    right_pixel_i,
  input  wire logic [rpc_pkg::PixW-1:0]    up_pixel_i,
  input  wire logic [rpc_pkg::PixW-1:0]    down_pixel_i,
  input  wire logic                        first_col_i,
  input  wire logic                        last_col_i,
  input  wire logic                        first_row_i,
  input  wire logic                        last_row_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rpc_pkg::PixW-1:0]         new_pixel_o,
  output logic                             write_enable_o
);
  import rpc_pkg::*;

  cfg_t            cfg_q;
  item_t           item_q;
  logic            item_v_q;
  mid_t            mid_d, mid_q;
  logic            mid_v_q;
  logic [PixW-1:0] pixel_d;
  logic [PixW-1:0] new_pixel_q;
  logic            we_q;
  logic            out_v_q;
  logic            out_adv;
  logic            mid_adv;
  logic            in_acc;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.format_rgb565 <= 1'b1;
      cfg_q.key_colour    <= NO_KEY;
      cfg_q.blend_percent <= '0;
      cfg_q.tint_red      <= '0;
      cfg_q.tint_green    <= '0;
      cfg_q.tint_blue     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FORMAT: cfg_q.format_rgb565 <= cfg_data_i[0];
        CFG_KEY:    cfg_q.key_colour    <= cfg_data_i;
        CFG_BLEND:  cfg_q.blend_percent <= cfg_data_i[6:0];
        CFG_TINT_R: cfg_q.tint_red      <= cfg_data_i[7:0];
        CFG_TINT_G: cfg_q.tint_green    <= cfg_data_i[7:0];
        CFG_TINT_B: cfg_q.tint_blue     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Each stage moves on when the stage after it is empty or moving.
  assign out_adv    = !out_v_q || out_ready_i;
  assign mid_adv    = !mid_v_q || out_adv;
  assign in_ready_o = !item_v_q || mid_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (in_ready_o) begin
      item_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.command     <= command_i;
      item_q.src_pixel   <= src_pixel_i;
      item_q.dst_pixel   <= dst_pixel_i;
      item_q.left_pixel  <= left_pixel_i;
      item_q.right_pixel <= right_pixel_i;
      item_q.up_pixel    <= up_pixel_i;
      item_q.down_pixel  <= down_pixel_i;
      item_q.first_col   <= first_col_i;
      item_q.last_col    <= last_col_i;
      item_q.first_row   <= first_row_i;
      item_q.last_row    <= last_row_i;
    end
  end

  // Classification and weighted sums.
  rpc_prep u_prep (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .mid_o  (mid_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
    end else if (mid_adv) begin
      mid_v_q <= item_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_adv && item_v_q) begin
      mid_q <= mid_d;
    end
  end

  // Division and packing.
  rpc_finish u_finish (
    .mid_i   (mid_q),
    .pixel_o (pixel_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= mid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && mid_v_q) begin
      new_pixel_q <= pixel_d;
      we_q        <= mid_q.write_enable;
    end
  end

  assign out_valid_o    = out_v_q;
  assign new_pixel_o    = new_pixel_q;
  assign write_enable_o = we_q;

  // The input side only stalls when every stage holds a word and the output waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (item_v_q && mid_v_q && out_v_q && !out_ready_i))
    else $error("input stalled while the pipeline has room");

  // A skipped pixel always carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !we_q) |-> (new_pixel_q == '0))
    else $error("skipped pixel with non-zero value");

  // A computed pixel never has its lowest green bit set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_v_q && out_adv && (mid_q.kind != RES_COPY)) |=> !new_pixel_q[5])
    else $error("computed pixel has lowest green bit set");

  // A stalled middle stage keeps its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_v_q && !out_adv) |=> (mid_v_q && $stable(mid_q)))
    else $error("middle stage lost its word during a stall");

endmodule

`default_nettype wire
